/* rtl/core/lmpf_pkg.sv */
// ----------------------------------------------------------------------------
// lmpf_pkg: shared definitions for the logistic map period finder
// Widths, register indexes, reset and depth defaults, sequencer state type.
// ----------------------------------------------------------------------------
package lmpf_pkg;

    // Q0.32 orbit point and Q2.30 growth rate.
    localparam int X_W    = 32;
    localparam int RATE_W = 32;
    localparam int STEP_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP  = 2'd1;

    localparam logic [X_W-1:0]    START_X_RESET = 32'h8000_0000;
    localparam logic [STEP_W-1:0] WARMUP_RESET  = 16'd10000;

    localparam int HISTORY_DEPTH_DEF = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WARM_SQ,
        ST_WARM_MUL,
        ST_DET_SQ,
        ST_DET_MUL,
        ST_CHECK,
        ST_SEEK,
        ST_EMIT
    } t_state;

endpackage

/* rtl/core/logistic_map_period_finder_core.sv */
// ----------------------------------------------------------------------------
// logistic_map_period_finder_core: orbit cycle detector for the logistic map
// Runs x = r*x*(1-x) in fixed point from a configured start, then looks for
// the first exact repeat in the history cells and streams the cycle or history.
// ----------------------------------------------------------------------------
// A run begins when start is seen high while busy is low; the growth rate is
// taken in that beat and busy stays high until the last result is sent. Each
// result appears on the output ports for exactly one cycle with o_valid high,
// and the receiver has no way to hold it off, so it must take every beat as
// it comes. Results of one run follow in consecutive cycles, the last one with
// o_last_point set. Every map step goes twice through the single shared map
// unit (square, then rate multiply), every new point is compared against the
// cell chain, and the chain is shifted up to HISTORY_DEPTH-1 times to bring
// the oldest cycle point to its output tap. The default warm-up is 10000
// steps. Configuration writes are only meant while busy is low.
// ----------------------------------------------------------------------------
module logistic_map_period_finder_core #(
    parameter int HISTORY_DEPTH = lmpf_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [lmpf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lmpf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Command side.
    input  logic                            start,
    output logic                            busy,
    input  logic [lmpf_pkg::RATE_W-1:0]     i_growth_rate,
    // Result side.
    output logic                            o_valid,
    output logic [lmpf_pkg::RATE_W-1:0]     o_rate_echo,
    output logic [lmpf_pkg::X_W-1:0]        o_cycle_point,
    output logic                            o_cycle_found,
    output logic                            o_last_point
);

    localparam int XW     = lmpf_pkg::X_W;
    localparam int IW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

    localparam logic [IW-1:0]     LAST_CELL = IW'(HISTORY_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH - 1);

    // Configuration registers.
    logic [XW-1:0]              r_start_x;
    logic [lmpf_pkg::STEP_W-1:0] r_warmup;

    // Sequencer and datapath registers.
    lmpf_pkg::t_state            r_state, n_state;
    logic [lmpf_pkg::RATE_W-1:0] r_rate, n_rate;
    logic [XW-1:0]               r_x, n_x;
    logic [lmpf_pkg::STEP_W-1:0] r_step, n_step;
    logic [FILL_W-1:0]           r_fill, n_fill;
    logic [IW-1:0]               r_seek, n_seek;
    logic [IW-1:0]               r_emit, n_emit;
    logic                        r_found, n_found;

    // Output registers.
    logic                        r_out_valid, n_out_valid;
    logic [XW-1:0]               r_out_point, n_out_point;
    logic                        r_out_last, n_out_last;

    // Control toward the map unit and the cell chain.
    logic                        w_sq_en;
    logic                        w_shift;
    logic [XW-1:0]               w_x_next;

    // Cell chain wiring: w_chain[j] is the point held in cell j.
    logic [XW-1:0]               w_chain [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]    w_match;
    logic                        w_any_match;
    logic [IW-1:0]               w_match_idx;
    logic                        w_accept;

    assign w_accept = start && (r_state == lmpf_pkg::ST_IDLE);

    // ------------------------------------------------------------------
    // Configuration registers take a write in any cycle it is offered.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= lmpf_pkg::START_X_RESET;
            r_warmup  <= lmpf_pkg::WARMUP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lmpf_pkg::CFG_START_X: begin
                    r_start_x <= i_cfg_data[XW-1:0];
                end
                lmpf_pkg::CFG_WARMUP: begin
                    r_warmup <= i_cfg_data[lmpf_pkg::STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared map unit.
    // ------------------------------------------------------------------
    lmpf_map_unit u_map (
        .i_clk    (i_clk),
        .i_sq_en  (w_sq_en),
        .i_x      (r_x),
        .i_rate   (r_rate),
        .o_x_next (w_x_next)
    );

    // ------------------------------------------------------------------
    // History chain. A new point enters cell 0 and older points move one
    // cell further on every shift, so cell j holds the point stored j
    // shifts ago. The last cell is the output tap.
    // ------------------------------------------------------------------
    for (genvar j = 0; j < HISTORY_DEPTH; j++) begin : g_cell
        logic [XW-1:0] w_in;
        if (j == 0) begin : g_head
            assign w_in = r_x;
        end else begin : g_body
            assign w_in = w_chain[j-1];
        end

        lmpf_cell #(
            .INDEX  (j),
            .FILL_W (FILL_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_data  (w_in),
            .i_probe (r_x),
            .i_fill  (r_fill),
            .o_data  (w_chain[j]),
            .o_match (w_match[j])
        );
    end

    // Stored points of a run are all distinct, so at most one cell matches
    // and its index can be formed by OR-ing instead of a priority search.
    always_comb begin
        w_match_idx = '0;
        for (int j = 0; j < HISTORY_DEPTH; j++) begin
            if (w_match[j]) begin
                w_match_idx = w_match_idx | IW'(j);
            end
        end
    end

    assign w_any_match = |w_match;

    // ------------------------------------------------------------------
    // Next-state logic.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lmpf_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = lmpf_pkg::ST_WARM_SQ;
                end
            end
            lmpf_pkg::ST_WARM_SQ: begin
                if (r_step == r_warmup) begin
                    n_state = lmpf_pkg::ST_DET_SQ;
                end else begin
                    n_state = lmpf_pkg::ST_WARM_MUL;
                end
            end
            lmpf_pkg::ST_WARM_MUL: begin
                n_state = lmpf_pkg::ST_WARM_SQ;
            end
            lmpf_pkg::ST_DET_SQ: begin
                n_state = lmpf_pkg::ST_DET_MUL;
            end
            lmpf_pkg::ST_DET_MUL: begin
                n_state = lmpf_pkg::ST_CHECK;
            end
            lmpf_pkg::ST_CHECK: begin
                if (w_any_match || (r_fill == FILL_FULL)) begin
                    n_state = lmpf_pkg::ST_SEEK;
                end else begin
                    n_state = lmpf_pkg::ST_DET_SQ;
                end
            end
            lmpf_pkg::ST_SEEK: begin
                if (r_seek == '0) begin
                    n_state = lmpf_pkg::ST_EMIT;
                end
            end
            lmpf_pkg::ST_EMIT: begin
                if (r_emit == IW'(1)) begin
                    n_state = lmpf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lmpf_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and output control.
    // ------------------------------------------------------------------
    always_comb begin
        n_rate      = r_rate;
        n_x         = r_x;
        n_step      = r_step;
        n_fill      = r_fill;
        n_seek      = r_seek;
        n_emit      = r_emit;
        n_found     = r_found;
        n_out_valid = 1'b0;
        n_out_point = r_out_point;
        n_out_last  = 1'b0;
        w_sq_en     = 1'b0;
        w_shift     = 1'b0;
        case (r_state)
            lmpf_pkg::ST_IDLE: begin
                if (start) begin
                    n_rate = i_growth_rate;
                    n_x    = r_start_x;
                    n_step = '0;
                    n_fill = '0;
                end
            end
            lmpf_pkg::ST_WARM_SQ: begin
                w_sq_en = (r_step != r_warmup);
            end
            lmpf_pkg::ST_WARM_MUL: begin
                n_x    = w_x_next;
                n_step = r_step + lmpf_pkg::STEP_W'(1);
            end
            lmpf_pkg::ST_DET_SQ: begin
                w_sq_en = 1'b1;
            end
            lmpf_pkg::ST_DET_MUL: begin
                n_x = w_x_next;
            end
            lmpf_pkg::ST_CHECK: begin
                if (w_any_match) begin
                    // The matching cell must travel to the tap; it and all
                    // younger cells form the cycle.
                    n_found = 1'b1;
                    n_seek  = LAST_CELL - w_match_idx;
                    n_emit  = w_match_idx + IW'(1);
                end else begin
                    w_shift = 1'b1;
                    n_fill  = r_fill + FILL_W'(1);
                    if (r_fill == FILL_FULL) begin
                        // History full: the oldest point already sits at
                        // the tap, and the newest one is not sent.
                        n_found = 1'b0;
                        n_seek  = '0;
                        n_emit  = LAST_CELL;
                    end
                end
            end
            lmpf_pkg::ST_SEEK: begin
                if (r_seek != '0) begin
                    w_shift = 1'b1;
                    n_seek  = r_seek - IW'(1);
                end
            end
            lmpf_pkg::ST_EMIT: begin
                w_shift     = 1'b1;
                n_emit      = r_emit - IW'(1);
                n_out_valid = 1'b1;
                n_out_point = w_chain[HISTORY_DEPTH-1];
                n_out_last  = (r_emit == IW'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lmpf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_step      <= '0;
            r_fill      <= '0;
            r_seek      <= '0;
            r_emit      <= '0;
            r_found     <= 1'b0;
            r_x         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
            r_step      <= n_step;
            r_fill      <= n_fill;
            r_seek      <= n_seek;
            r_emit      <= n_emit;
            r_found     <= n_found;
            r_x         <= n_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rate      <= n_rate;
        r_out_point <= n_out_point;
    end

    assign busy          = (r_state != lmpf_pkg::ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_rate_echo   = r_rate;
    assign o_cycle_point = r_out_point;
    assign o_cycle_found = r_found;
    assign o_last_point  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_accept_starts_warmup : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == lmpf_pkg::ST_WARM_SQ)
    ) else $error("accepted command did not start the warm-up");

    a_single_match : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lmpf_pkg::ST_CHECK) |-> $onehot0(w_match)
    ) else $error("more than one history cell matched");

    a_fill_in_range : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lmpf_pkg::ST_CHECK) |-> (r_fill <= FILL_FULL)
    ) else $error("history compare with the chain already full");

    a_beat_from_emit : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == lmpf_pkg::ST_EMIT)
    ) else $error("result beat outside the emit phase");

    // The last beat goes out while the block is already idle, so a new
    // command can be taken in that same cycle.
    a_last_ends_run : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_point) |-> (!busy ##1 !o_valid)
    ) else $error("busy during or beat after the last point of a run");

endmodule

/* rtl/core/lmpf_map_unit.sv */
// ----------------------------------------------------------------------------
// lmpf_map_unit: one logistic map step, squaring then rate scaling
// The square step registers x*x. The multiply step forms x*(1-x) from it and scales
// by the growth rate; the caller registers the new point.
// ----------------------------------------------------------------------------
module lmpf_map_unit (
    input  logic                          i_clk,
    input  logic                          i_sq_en,
    input  logic [lmpf_pkg::X_W-1:0]      i_x,
    input  logic [lmpf_pkg::RATE_W-1:0]   i_rate,
    output logic [lmpf_pkg::X_W-1:0]      o_x_next
);

    localparam int XW   = lmpf_pkg::X_W;
    localparam int P_W  = XW - 1;
    localparam int PR_W = lmpf_pkg::RATE_W + P_W;

    logic [2*XW-1:0] r_sq;
    logic [2*XW-1:0] n_sq;
    logic [XW:0]     w_p_full;
    logic [P_W-1:0]  w_p;
    logic [PR_W-1:0] w_prod;

    assign n_sq = (2*XW)'(i_x) * (2*XW)'(i_x);

    always_ff @(posedge i_clk) begin
        if (i_sq_en) begin
            r_sq <= n_sq;
        end
    end

    // x*(1-x) truncated equals x minus the ceiling of x*x in Q0.32.
    assign w_p_full = {1'b0, i_x} - {1'b0, r_sq[2*XW-1:XW]}
                    - (XW+1)'(|r_sq[XW-1:0]);
    assign w_p      = w_p_full[P_W-1:0];

    // The product stays below 2^62, so the shifted result always fits.
    assign w_prod   = PR_W'(i_rate) * PR_W'(w_p);
    assign o_x_next = w_prod[XW+P_W-2:P_W-1];

endmodule

/* rtl/core/lmpf_cell.sv */
// ----------------------------------------------------------------------------
// lmpf_cell: one history cell of the shift chain
// Holds one stored point, takes its neighbor's point on a shift and flags
// an exact match against the probe when it holds a point of this run.
// ----------------------------------------------------------------------------
module lmpf_cell #(
    parameter int INDEX  = 0,
    parameter int FILL_W = 7
) (
    input  logic                      i_clk,
    input  logic                      i_shift,
    input  logic [lmpf_pkg::X_W-1:0]  i_data,
    input  logic [lmpf_pkg::X_W-1:0]  i_probe,
    input  logic [FILL_W-1:0]         i_fill,
    output logic [lmpf_pkg::X_W-1:0]  o_data,
    output logic                      o_match
);

    logic [lmpf_pkg::X_W-1:0] r_data;
    logic                     w_live;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign w_live  = FILL_W'(INDEX) < i_fill;
    assign o_match = w_live && (r_data == i_probe);
    assign o_data  = r_data;

endmodule
